FILE: hw/rtl/cfrf_pkg.sv
// Shared types and constants for the character framebuffer with rectangle fill.
// Used by cfrf_sweep and char_framebuffer_rect_fill; depends on nothing else.
package cfrf_pkg;

   // Character written by clear and by the clearing pass after reset
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // Command codes carried on req_func
   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_FILL  = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   // Configuration register indexes
   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   // Control states of the top level
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SWEEP,
      ST_READ,
      ST_HOLD
   } state_type;

   // Rectangle handed to the sweep sequencer (columns and rows, end exclusive)
   typedef struct packed {
      logic [7:0] x_start;
      logic [7:0] col_end;
      logic [6:0] row_start;
      logic [6:0] row_end;
      logic [7:0] stride;
   } sweep_cmd_type;

   // Sweep sequencer status
   typedef struct packed {
      logic busy;
      logic last;
   } sweep_stat_type;

endpackage

FILE: hw/rtl/cfrf_sweep.sv
// Address sequencer that walks a rectangle of cells, one cell per cycle, row by row.
// Depends on cfrf_pkg for the command and status structs.
module cfrf_sweep import cfrf_pkg::*; #(
   parameter int unsigned AW = 15
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  sweep_cmd_type  cmd,
   input  logic [AW-1:0]  base,
   output sweep_stat_type stat,
   output logic [AW-1:0]  addr
);

   logic          busy_ff, busy_in;
   sweep_cmd_type cmd_ff;
   logic [7:0]    col_ff, col_in;
   logic [6:0]    row_ff, row_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] row_base_ff, row_base_in;

   logic [8:0]    col_next;
   logic [7:0]    row_next;
   logic          col_last, row_last;
   logic [AW-1:0] row_base_next;

   // Detect the end of the current row and of the rectangle
   assign col_next      = {1'b0, col_ff} + 9'd1;
   assign row_next      = {1'b0, row_ff} + 8'd1;
   assign col_last      = (col_next == {1'b0, cmd_ff.col_end});
   assign row_last      = (row_next == {1'b0, cmd_ff.row_end});
   assign row_base_next = row_base_ff + AW'(cmd_ff.stride);

   // Advance along the row, then step down to the next row
   always_comb begin
      busy_in     = busy_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      addr_in     = addr_ff;
      row_base_in = row_base_ff;
      if (start) begin
         busy_in     = 1'b1;
         col_in      = cmd.x_start;
         row_in      = cmd.row_start;
         addr_in     = base;
         row_base_in = base;
      end else if (busy_ff) begin
         if (!col_last) begin
            col_in  = col_next[7:0];
            addr_in = addr_ff + AW'(1);
         end else if (!row_last) begin
            col_in      = cmd_ff.x_start;
            row_in      = row_next[6:0];
            row_base_in = row_base_next;
            addr_in     = row_base_next;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff <= cmd;
      end
      col_ff      <= col_in;
      row_ff      <= row_in;
      addr_ff     <= addr_in;
      row_base_ff <= row_base_in;
   end

   assign stat.busy = busy_ff;
   assign stat.last = busy_ff & col_last & row_last;
   assign addr      = addr_ff;

endmodule

FILE: hw/rtl/char_framebuffer_rect_fill.sv
// Character framebuffer with rectangle fill: one byte per cell, row-major at y*width+x.
// Commands arrive on the req_ channel (clear, write cell, fill rectangle, read cell)
// and each gives exactly one word on the rsp_ channel (read_char, status).
// Active area is set through the csr_ port (width, height); write it only while idle.
// Flow, one command at a time:
//   write cell      written as taken; a new command can follow unless the result must park
//   read cell       one single-port RAM read, then the result register
//   clear / fill    the sweep writes each touched cell in turn; empty rectangles write none
// The cell RAM has one port, so it serves one cell write or read at a time.
// The result sits in an output register; the block takes the next command while
// it waits. If rsp_stall holds a word and another result is due, the block parks in
// a hold state (a read in its read state) and stalls req_ until the word is taken.
// After reset a clearing pass writes a space to every one of the MAX_COLS*MAX_ROWS
// RAM entries (8192 at the defaults), one per cycle; req_stall is high meanwhile,
// while csr_ writes are taken at any time.
// Depends on cfrf_pkg and cfrf_sweep.
module char_framebuffer_rect_fill import cfrf_pkg::*; #(
   parameter int unsigned MAX_COLS = 128,
   parameter int unsigned MAX_ROWS = 64
) (
   input  logic       clock,
   input  logic       reset,
   // command channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [6:0] req_pos_x,
   input  logic [5:0] req_pos_y,
   input  logic [7:0] req_rect_width,
   input  logic [6:0] req_rect_height,
   input  logic [7:0] req_fill_char,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_char,
   output logic       rsp_status,
   // configuration port
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int unsigned DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CALC_W = (ADDR_W > 15) ? ADDR_W : 15;
   localparam logic [7:0]  COL_CAP = (MAX_COLS > 255) ? 8'd255 : 8'(MAX_COLS);
   localparam logic [6:0]  ROW_CAP = (MAX_ROWS > 127) ? 7'd127 : 7'(MAX_ROWS);
   localparam logic [ADDR_W-1:0] INIT_LAST = ADDR_W'(DEPTH - 1);

   // Configuration registers
   logic [7:0] width_ff;
   logic [6:0] height_ff;
   logic [7:0] eff_w;
   logic [6:0] eff_h;

   // Control
   state_type state_ff, state_in;
   logic [ADDR_W-1:0] init_addr_ff, init_addr_in;
   logic [7:0] char_ff;
   logic       rd_oor_ff;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff;
   logic       rsp_status_ff;
   logic       rsp_free;
   logic       rsp_load;
   logic [7:0] rsp_char_in;
   logic       rsp_status_in;

   // Command decode
   func_type   func;
   logic       req_fire;
   logic       in_range;
   logic [7:0] fx;
   logic [6:0] fy;
   logic [7:0] frw;
   logic [6:0] frh;
   logic [8:0] col_sum;
   logic [7:0] row_sum;
   logic       sweep_empty;
   logic [CALC_W-1:0] cell_addr;
   sweep_cmd_type     sweep_cmd;
   logic              sweep_start;
   sweep_stat_type    sweep_stat;
   logic [CALC_W-1:0] sweep_addr;
   logic              fin_now;

   // Cell RAM
   logic [7:0]        mem [DEPTH];
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]        mem_wdata;
   logic [7:0]        mem_q_ff;

   // Take configuration writes at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd128;
         height_ff <= 7'd64;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_WIDTH:  width_ff  <= csr_wdata;
            REG_HEIGHT: height_ff <= csr_wdata[6:0];
         endcase
      end
   end

   // Clamp the active area to the store size
   assign eff_w = (width_ff > COL_CAP) ? COL_CAP : width_ff;
   assign eff_h = (height_ff > ROW_CAP) ? ROW_CAP : height_ff;

   // Decode the command word; clear is a fill of the whole area with a space
   assign func      = func_type'(req_func);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid & ~req_stall;
   assign in_range  = ({1'b0, req_pos_x} < eff_w) && ({1'b0, req_pos_y} < eff_h);

   always_comb begin
      if (func == FUNC_CLEAR) begin
         fx  = 8'd0;
         fy  = 7'd0;
         frw = eff_w;
         frh = eff_h;
      end else begin
         fx  = {1'b0, req_pos_x};
         fy  = {1'b0, req_pos_y};
         frw = req_rect_width;
         frh = req_rect_height;
      end
   end

   assign col_sum     = {1'b0, fx} + {1'b0, frw};
   assign row_sum     = {1'b0, fy} + {1'b0, frh};
   assign sweep_empty = !((fx < eff_w) && (fy < eff_h)) || (frw == 8'd0) || (frh == 7'd0);
   assign cell_addr   = CALC_W'(fy) * CALC_W'(eff_w) + CALC_W'(fx);

   assign sweep_cmd.x_start   = fx;
   assign sweep_cmd.row_start = fy;
   assign sweep_cmd.col_end   = (col_sum > {1'b0, eff_w}) ? eff_w : col_sum[7:0];
   assign sweep_cmd.row_end   = (row_sum > {1'b0, eff_h}) ? eff_h : row_sum[6:0];
   assign sweep_cmd.stride    = eff_w;
   assign sweep_start = req_fire && ((func == FUNC_CLEAR) || (func == FUNC_FILL)) &&
                        !sweep_empty;

   cfrf_sweep #(
      .AW (CALC_W)
   ) u_sweep (
      .clock (clock),
      .reset (reset),
      .start (sweep_start),
      .cmd   (sweep_cmd),
      .base  (cell_addr),
      .stat  (sweep_stat),
      .addr  (sweep_addr)
   );

   // Commands whose result is known in the cycle they are taken
   assign fin_now = req_fire && ((func == FUNC_WRITE) ||
                    (((func == FUNC_CLEAR) || (func == FUNC_FILL)) && sweep_empty));

   assign rsp_free = ~rsp_valid_ff | ~rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (init_addr_ff == INIT_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (func == FUNC_READ) begin
                  state_in = ST_READ;
               end else if (sweep_start) begin
                  state_in = ST_SWEEP;
               end else if (!rsp_free) begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_SWEEP: begin
            if (sweep_stat.last) state_in = rsp_free ? ST_IDLE : ST_HOLD;
         end
         ST_READ: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         ST_HOLD: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Outputs: RAM port and result load
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = cell_addr[ADDR_W-1:0];
      mem_wdata = req_fill_char;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_addr  = init_addr_ff;
            mem_wdata = SPACE_CHAR;
         end
         ST_IDLE: begin
            mem_we   = req_fire && (func == FUNC_WRITE) && in_range;
            mem_re   = req_fire && (func == FUNC_READ) && in_range;
            rsp_load = fin_now && rsp_free;
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_addr  = sweep_addr[ADDR_W-1:0];
            mem_wdata = char_ff;
            rsp_load  = sweep_stat.last && rsp_free;
         end
         ST_READ: rsp_load = rsp_free;
         ST_HOLD: rsp_load = rsp_free;
         default: ;
      endcase
   end

   // Result word: only reads carry data or status
   assign rsp_char_in   = ((state_ff == ST_READ) && !rd_oor_ff) ? mem_q_ff : 8'd0;
   assign rsp_status_in = (state_ff == ST_READ) && rd_oor_ff;
   assign rsp_valid_in  = rsp_load | (rsp_valid_ff & rsp_stall);
   assign init_addr_in  = init_addr_ff + ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_INIT) init_addr_ff <= init_addr_in;
      end
   end

   // Hold command payload and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         char_ff   <= (func == FUNC_CLEAR) ? SPACE_CHAR : req_fill_char;
         rd_oor_ff <= ~in_range;
      end
      if (rsp_load) begin
         rsp_char_ff   <= rsp_char_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Single-port cell RAM, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (mem_re) mem_q_ff <= mem[mem_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_char = rsp_char_ff;
   assign rsp_status    = rsp_status_ff;

`ifndef ASSERT_OFF
   // The sweep sequencer runs exactly while the control sits in the sweep state
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) == sweep_stat.busy)
      else $error("sweep sequencer out of step with control state");

   // A waiting result word is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("result register overwritten while stalled");

   // The RAM is quiet while a read result or a parked result is pending
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_HOLD)) |-> (!mem_we && !mem_re))
      else $error("RAM access during result wait");

   // An accepted read moves to the read state
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (func == FUNC_READ)) |=> (state_ff == ST_READ))
      else $error("read not followed by read state");

   // Sweep addresses stay inside the store
   assert property (@(posedge clock) disable iff (reset)
      sweep_stat.busy |-> (sweep_addr < CALC_W'(DEPTH)))
      else $error("sweep address outside the store");
`endif

endmodule
